[rtl/bpde_pkg.sv]
`default_nettype none
package bpde_pkg;

  localparam int BLOCK_MAX   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(BLOCK_MAX);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int RAM_DEPTH   = 2 * BLOCK_MAX;
  localparam int RAM_AW      = ADDR_W + 1;
  localparam int RAM_W       = 2 * SAMPLE_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;

  localparam logic signed [17:0] DB_FLOOR      = -18'sd25600;
  localparam logic signed [17:0] DB_PER_OCTAVE = 18'sd1541;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_GAIN    = 3'd0,
    REG_FEEDBACK_ONE = 3'd1,
    REG_FEEDBACK_TWO = 3'd2,
    REG_THRESHOLD_DB = 3'd3,
    REG_SLOPE        = 3'd4,
    REG_RANGE_DB     = 3'd5,
    REG_LISTEN_MODE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [16:0] band_gain;
    logic signed [18:0] feedback_one;
    logic signed [17:0] feedback_two;
    logic signed [15:0] threshold_db;
    logic        [15:0] slope;
    logic        [14:0] range_db;
    logic               listen_mode;
  } cfg_t;

  // One closed block handed from the filter side to the output side.
  typedef struct packed {
    logic                   bank;
    logic [CNT_W-1:0]       count;
    logic                   last;
    logic [SAMPLE_BITS-1:0] peak;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [10:0] logt(input logic [4:0] k);
    logic [10:0] v;
    case (k)
      5'd0:    v = 11'd0;
      5'd1:    v = 11'd135;
      5'd2:    v = 11'd262;
      5'd3:    v = 11'd382;
      5'd4:    v = 11'd496;
      5'd5:    v = 11'd605;
      5'd6:    v = 11'd708;
      5'd7:    v = 11'd807;
      5'd8:    v = 11'd902;
      5'd9:    v = 11'd992;
      5'd10:   v = 11'd1080;
      5'd11:   v = 11'd1163;
      5'd12:   v = 11'd1244;
      5'd13:   v = 11'd1322;
      5'd14:   v = 11'd1398;
      5'd15:   v = 11'd1471;
      default: v = 11'd1541;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] expt(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd31379;
      5'd2:    v = 16'd30048;
      5'd3:    v = 16'd28774;
      5'd4:    v = 16'd27554;
      5'd5:    v = 16'd26386;
      5'd6:    v = 16'd25267;
      5'd7:    v = 16'd24196;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd22188;
      5'd10:   v = 16'd21247;
      5'd11:   v = 16'd20347;
      5'd12:   v = 16'd19484;
      5'd13:   v = 16'd18658;
      5'd14:   v = 16'd17867;
      5'd15:   v = 16'd17110;
      default: v = 16'd16384;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/bpde_ram.sv]
`default_nettype none
module bpde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/bpde_fifo.sv]
`default_nettype none
module bpde_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bpde_pkg::desc_t push_data_i,
  input  wire logic            pop_i,
  output bpde_pkg::desc_t      head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  bpde_pkg::desc_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/bpde_front.sv]
`default_nettype none
module bpde_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bpde_pkg::cfg_t                    cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [bpde_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic                              in_last_i,
  output logic                                   wr_en_o,
  output logic [bpde_pkg::RAM_AW-1:0]            wr_addr_o,
  output logic [bpde_pkg::RAM_W-1:0]             wr_data_o,
  output logic                                   push_o,
  output bpde_pkg::desc_t                        desc_o,
  input  wire logic                              q_full_i,
  input  wire bpde_pkg::rel_t                    rel_i
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_ACC, F_FB, F_UPD} fstate_e;

  fstate_e state_q, state_d;
  logic signed [15:0] x_q, x_d;
  logic               last_q, last_d;
  logic signed [33:0] p0_q, p0_d;
  logic signed [15:0] y_q, y_d;
  logic signed [34:0] pa1_q, pa1_d;
  logic signed [33:0] pa2_q, pa2_d;
  logic signed [31:0] s1_q, s1_d;
  logic signed [31:0] s2_q, s2_d;
  logic [bpde_pkg::ADDR_W-1:0] fill_q, fill_d;
  logic [15:0] peak_q, peak_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d;

  logic signed [34:0] acc, acc_r;
  logic signed [18:0] y_sh;
  logic signed [15:0] y_sat;
  logic signed [16:0] y_neg;
  logic [15:0]        mag, peak_new;
  logic               close;

  always_comb begin
    acc   = 35'(p0_q) + 35'(s1_q);
    acc_r = acc + 35'sd32768;
    y_sh  = acc_r[34:16];
    if (y_sh > 19'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y_sh < -19'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_sh[15:0];
    end
    y_neg    = -17'(y_q);
    mag      = y_q[15] ? y_neg[15:0] : y_q;
    peak_new = (mag > peak_q) ? mag : peak_q;
    close    = last_q || (fill_q == bpde_pkg::ADDR_W'(bpde_pkg::BLOCK_MAX - 1));
  end

  assign in_ready_o = (state_q == F_IDLE) && !busy_q[bank_q];
  assign wr_en_o    = (state_q == F_UPD);
  assign wr_addr_o  = {bank_q, fill_q};
  assign wr_data_o  = {y_q, x_q};
  assign push_o     = (state_q == F_UPD) && close;

  always_comb begin
    desc_o.bank  = bank_q;
    desc_o.count = bpde_pkg::CNT_W'(fill_q) + bpde_pkg::CNT_W'(1);
    desc_o.last  = last_q;
    desc_o.peak  = peak_new;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    last_d  = last_q;
    p0_d    = p0_q;
    y_d     = y_q;
    pa1_d   = pa1_q;
    pa2_d   = pa2_q;
    s1_d    = s1_q;
    s2_d    = s2_q;
    fill_d  = fill_q;
    peak_d  = peak_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          x_d     = in_sample_i;
          last_d  = in_last_i;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        p0_d    = $signed({1'b0, cfg_i.band_gain}) * x_q;
        state_d = F_ACC;
      end
      F_ACC: begin
        y_d     = y_sat;
        state_d = F_FB;
      end
      F_FB: begin
        pa1_d   = cfg_i.feedback_one * y_q;
        pa2_d   = cfg_i.feedback_two * y_q;
        state_d = F_UPD;
      end
      F_UPD: begin
        s1_d = bpde_pkg::sat32(36'(s2_q) - 36'(pa1_q));
        s2_d = bpde_pkg::sat32(-36'(p0_q) - 36'(pa2_q));
        if (close) begin
          fill_d         = '0;
          peak_d         = '0;
          bank_d         = ~bank_q;
          busy_d[bank_q] = 1'b1;
        end else begin
          fill_d = fill_q + bpde_pkg::ADDR_W'(1);
          peak_d = peak_new;
        end
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      s1_q    <= '0;
      s2_q    <= '0;
      fill_q  <= '0;
      peak_q  <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      state_q <= state_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      fill_q  <= fill_d;
      peak_q  <= peak_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    last_q <= last_d;
    p0_q  <= p0_d;
    y_q   <= y_d;
    pa1_q <= pa1_d;
    pa2_q <= pa2_d;
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i) else $error("block queue overflow");
  a_write_free_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !busy_q[bank_q]) else $error("write into a bank still being read");
  a_release_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank]) else $error("release of an idle bank");
  a_close_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (fill_q == '0) && (peak_q == '0)) else $error("block state not cleared");

endmodule
`default_nettype wire

[rtl/bpde_back.sv]
`default_nettype none
module bpde_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bpde_pkg::cfg_t             cfg_i,
  input  wire bpde_pkg::desc_t            head_i,
  input  wire logic                       q_empty_i,
  output logic                            pop_o,
  output logic                            rd_en_o,
  output logic [bpde_pkg::RAM_AW-1:0]     rd_addr_o,
  input  wire logic [bpde_pkg::RAM_W-1:0] rd_data_i,
  output bpde_pkg::rel_t                  rel_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bpde_pkg::SAMPLE_BITS-1:0] out_sample_o,
  output logic                            out_last_o,
  output logic [15:0]                     out_gain_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_NORM, B_INTERP, B_LEVEL, B_EXCESS, B_RED, B_OCT, B_GAIN,
    B_READ, B_WAIT, B_EMIT
  } bstate_e;

  bstate_e state_q, state_d;
  bpde_pkg::desc_t d_q, d_d;
  logic [3:0]  e_q, e_d;
  logic [15:0] f_q, f_d;
  logic        zero_q, zero_d;
  logic [18:0] dprod_q, dprod_d;
  logic signed [17:0] lbase_q, lbase_d;
  logic signed [17:0] lvl_q, lvl_d;
  logic        below_q, below_d;
  logic [32:0] xprod_q, xprod_d;
  logic [30:0] octp_q, octp_d;
  logic [4:0]  n_q, n_d;
  logic [3:0]  k_q, k_d;
  logic [22:0] eprod_q, eprod_d;
  logic [15:0] gain_q, gain_d;
  logic [bpde_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic signed [15:0] orig_q, orig_d, band_q, band_d;
  logic signed [32:0] bg_q, bg_d;
  logic        ov_q, ov_d;
  logic [15:0] os_q, os_d;
  logic        ol_q, ol_d;
  logic [15:0] og_q, og_d;

  logic [3:0]  e_c;
  logic [14:0] q_c;
  logic [4:0]  k5;
  logic signed [17:0] eoff, lvl_c;
  logic [19:0] dround;
  logic signed [17:0] ex_c;
  logic [32:0] xround;
  logic [16:0] red17;
  logic [14:0] red;
  logic [30:0] oround;
  logic [20:0] oct;
  logic [4:0]  ok5;
  logic [16:0] eround;
  logic [15:0] m_c;
  logic [16:0] half, msum;
  logic signed [32:0] bround;
  logic signed [18:0] vsum;
  logic signed [15:0] v_c;
  logic        is_end, can_load;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (d_q.peak[i]) begin
        e_c = 4'(i);
      end
    end
    q_c    = f_q[14:0] ^ 15'd0;
    k5     = {1'b0, q_c[14:11]};
    eoff   = $signed({14'd0, e_q}) - 18'sd15;
    dround = 20'(dprod_q) + 20'd1024;
    lvl_c  = lbase_q + $signed({9'd0, dround[19:11]});
    ex_c   = lvl_q - 18'(cfg_i.threshold_db);
    xround = xprod_q + 33'd32768;
    red17  = xround[32:16];
    red    = (red17 > {2'b0, cfg_i.range_db}) ? cfg_i.range_db : red17[14:0];
    oround = octp_q + 31'd512;
    oct    = oround[30:10];
    ok5    = {1'b0, oct[15:12]};
    eround = 17'(eprod_q[22:12]) + 17'((eprod_q[11:0] + 13'd2048) >> 12);
    m_c    = bpde_pkg::expt({1'b0, k_q}) - eround[15:0];
    half   = (n_q == 5'd0) ? 17'd0 : (17'd1 << (n_q - 5'd1));
    msum   = (17'(m_c) + half) >> n_q;
    bround = bg_q + 33'sd16384;
    vsum   = 19'(orig_q) - 19'(band_q) + 19'($signed(bround[32:15]));
    if (cfg_i.listen_mode) begin
      v_c = band_q;
    end else if (vsum > 19'sd32767) begin
      v_c = 16'sh7FFF;
    end else if (vsum < -19'sd32768) begin
      v_c = -16'sh8000;
    end else begin
      v_c = vsum[15:0];
    end
    is_end   = (bpde_pkg::CNT_W'(idx_q) + bpde_pkg::CNT_W'(1)) == d_q.count;
    can_load = !ov_q || out_ready_i;
  end

  assign pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign rd_en_o   = (state_q == B_READ);
  assign rd_addr_o = {d_q.bank, idx_q};
  assign rel_o.valid = (state_q == B_EMIT) && can_load && is_end;
  assign rel_o.bank  = d_q.bank;
  assign out_valid_o  = ov_q;
  assign out_sample_o = os_q;
  assign out_last_o   = ol_q;
  assign out_gain_o   = og_q;

  always_comb begin
    state_d = state_q;
    d_d = d_q;  e_d = e_q;  f_d = f_q;  zero_d = zero_q;
    dprod_d = dprod_q;  lbase_d = lbase_q;  lvl_d = lvl_q;  below_d = below_q;
    xprod_d = xprod_q;  octp_d = octp_q;  n_d = n_q;  k_d = k_q;
    eprod_d = eprod_q;  gain_d = gain_q;  idx_d = idx_q;
    orig_d = orig_q;  band_d = band_q;  bg_d = bg_q;
    ov_d = ov_q;  os_d = os_q;  ol_d = ol_q;  og_d = og_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          d_d     = head_i;
          state_d = B_NORM;
        end
      end
      B_NORM: begin
        e_d     = e_c;
        f_d     = d_q.peak << (4'd15 - e_c);
        zero_d  = (d_q.peak == '0);
        state_d = B_INTERP;
      end
      B_INTERP: begin
        dprod_d = 19'(bpde_pkg::logt(k5 + 5'd1) - bpde_pkg::logt(k5)) * 19'(q_c[10:0]);
        lbase_d = 18'(eoff * bpde_pkg::DB_PER_OCTAVE) + $signed({7'd0, bpde_pkg::logt(k5)});
        state_d = B_LEVEL;
      end
      B_LEVEL: begin
        if (zero_q || lvl_c < bpde_pkg::DB_FLOOR) begin
          lvl_d = bpde_pkg::DB_FLOOR;
        end else begin
          lvl_d = lvl_c;
        end
        state_d = B_EXCESS;
      end
      B_EXCESS: begin
        below_d = ex_c[17];
        xprod_d = ex_c[16:0] * cfg_i.slope;
        state_d = B_RED;
      end
      B_RED: begin
        octp_d  = red * 16'd43541;
        state_d = B_OCT;
      end
      B_OCT: begin
        n_d     = oct[20:16];
        k_d     = oct[15:12];
        eprod_d = 23'(bpde_pkg::expt(ok5) - bpde_pkg::expt(ok5 + 5'd1)) * 23'(oct[11:0]);
        state_d = B_GAIN;
      end
      B_GAIN: begin
        if (below_q) begin
          gain_d = 16'd32768;
        end else if (n_q >= 5'd16) begin
          gain_d = '0;
        end else begin
          gain_d = msum[15:0];
        end
        idx_d   = '0;
        state_d = B_READ;
      end
      B_READ: begin
        state_d = B_WAIT;
      end
      B_WAIT: begin
        orig_d  = rd_data_i[15:0];
        band_d  = rd_data_i[31:16];
        bg_d    = $signed(rd_data_i[31:16]) * $signed({1'b0, gain_q});
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (can_load) begin
          ov_d = 1'b1;
          os_d = v_c;
          ol_d = is_end && d_q.last;
          og_d = gain_q;
          if (is_end) begin
            state_d = B_IDLE;
          end else begin
            idx_d   = idx_q + bpde_pkg::ADDR_W'(1);
            state_d = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;  e_q <= e_d;  f_q <= f_d;  zero_q <= zero_d;
    dprod_q <= dprod_d;  lbase_q <= lbase_d;  lvl_q <= lvl_d;  below_q <= below_d;
    xprod_q <= xprod_d;  octp_q <= octp_d;  n_q <= n_d;  k_q <= k_d;
    eprod_q <= eprod_d;  gain_q <= gain_d;  idx_q <= idx_d;
    orig_q <= orig_d;  band_q <= band_d;  bg_q <= bg_d;
    os_q <= os_d;  ol_q <= ol_d;  og_q <= og_d;
  end

endmodule
`default_nettype wire

[rtl/block_peak_de_esser_top.sv]
// Input side: each sample goes through filter multiply, accumulate, feedback
// multiply and state update in the recursive biquad sequencer, one at a time.
// After a block is queued its gain is computed, then each result goes through
// memory read, band times gain and output register, one at a time.
// Two memory banks let the next block fill while the previous one drains.
// Reset is asynchronous, active low.
`default_nettype none
module block_peak_de_esser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] sample_out, [31:16] gain
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [bpde_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpde_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bpde_pkg::cfg_t  cfg_q, cfg_d;
  bpde_pkg::desc_t push_data, head;
  bpde_pkg::rel_t  rel;
  logic push, pop, q_empty, q_full;
  logic wr_en, rd_en;
  logic [bpde_pkg::RAM_AW-1:0] wr_addr, rd_addr;
  logic [bpde_pkg::RAM_W-1:0]  wr_data, rd_data;
  logic [15:0] out_sample, out_gain;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bpde_pkg::REG_BAND_GAIN:    cfg_d.band_gain    = cfg_data_i[16:0];
        bpde_pkg::REG_FEEDBACK_ONE: cfg_d.feedback_one = cfg_data_i[18:0];
        bpde_pkg::REG_FEEDBACK_TWO: cfg_d.feedback_two = cfg_data_i[17:0];
        bpde_pkg::REG_THRESHOLD_DB: cfg_d.threshold_db = cfg_data_i[15:0];
        bpde_pkg::REG_SLOPE:        cfg_d.slope        = cfg_data_i[15:0];
        bpde_pkg::REG_RANGE_DB:     cfg_d.range_db     = cfg_data_i[14:0];
        bpde_pkg::REG_LISTEN_MODE:  cfg_d.listen_mode  = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_gain    <= '0;
      cfg_q.feedback_one <= '0;
      cfg_q.feedback_two <= '0;
      cfg_q.threshold_db <= -16'sd5120;
      cfg_q.slope        <= 16'd49152;
      cfg_q.range_db     <= 15'd3072;
      cfg_q.listen_mode  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .desc_o      (push_data),
    .q_full_i    (q_full),
    .rel_i       (rel)
  );

  bpde_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  bpde_ram #(
    .WIDTH (bpde_pkg::RAM_W),
    .DEPTH (bpde_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bpde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .rel_o        (rel),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_last_o   (m_axis_tlast),
    .out_gain_o   (out_gain)
  );

  assign m_axis_tdata = {out_gain, out_sample};

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected output samples of a de-esser block and compares results.
class deess_scoreboard;
  logic signed [17:0] band_gain_c;
  logic signed [18:0] fb_one_c;
  logic signed [17:0] fb_two_c;
  logic signed [15:0] thr_c;
  logic [15:0] slope_c;
  logic [14:0] range_c;
  logic listen_c;

  longint state_one, state_two;
  int orig_q[$];
  int band_q[$];
  int peak;

  logic [15:0] exp_sample[$];
  logic [15:0] exp_gain[$];
  bit exp_last[$];
  int errors;
  int results_seen;
  int blocks_seen;

  function void reset_model();
    band_gain_c = 0; fb_one_c = 0; fb_two_c = 0;
    thr_c = -16'sd5120; slope_c = 16'd49152; range_c = 15'd3072; listen_c = 0;
    state_one = 0; state_two = 0;
    orig_q = {}; band_q = {}; peak = 0;
    errors = 0; results_seen = 0; blocks_seen = 0;
  endfunction

  function void write_reg(bpde_pkg::reg_idx_e idx, logic [18:0] val);
    case (idx)
      bpde_pkg::REG_BAND_GAIN:    band_gain_c = {1'b0, val[16:0]};
      bpde_pkg::REG_FEEDBACK_ONE: fb_one_c = val[18:0];
      bpde_pkg::REG_FEEDBACK_TWO: fb_two_c = val[17:0];
      bpde_pkg::REG_THRESHOLD_DB: thr_c = val[15:0];
      bpde_pkg::REG_SLOPE:        slope_c = val[15:0];
      bpde_pkg::REG_RANGE_DB:     range_c = val[14:0];
      default:                    listen_c = val[0];
    endcase
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int log_tab(int k);
    int t[17] = '{0, 135, 262, 382, 496, 605, 708, 807, 902,
                  992, 1080, 1163, 1244, 1322, 1398, 1471, 1541};
    return t[k];
  endfunction

  function longint exp_tab(int k);
    int t[17] = '{32768, 31379, 30048, 28774, 27554, 26386, 25267, 24196, 23170,
                  22188, 21247, 20347, 19484, 18658, 17867, 17110, 16384};
    return t[k];
  endfunction

  function int level_db(int p);
    int e, f, q, k, r, lvl;
    if (p == 0) return -25600;
    e = 0;
    while (e < 31 && (p >> (e + 1)) != 0) e++;
    f = (e >= 15) ? (p >> (e - 15)) : (p << (15 - e));
    q = (f - 32768) & 32'h7fff;
    k = q >> 11;
    r = q & 2047;
    lvl = (e - 15) * 1541 + log_tab(k) + (((log_tab(k + 1) - log_tab(k)) * r + 1024) >>> 11);
    return lvl < -25600 ? -25600 : lvl;
  endfunction

  function longint block_gain(int lvl);
    longint excess, red, oct, n, k, r, m;
    if (lvl < longint'(thr_c)) return 32768;
    excess = lvl - longint'(thr_c);
    red = (excess * longint'(slope_c) + 32768) >>> 16;
    if (red > longint'(range_c)) red = range_c;
    oct = (red * 43541 + 512) >>> 10;
    n = oct >>> 16;
    if (n >= 16) return 0;
    k = (oct >>> 12) & 15;
    r = oct & 4095;
    m = exp_tab(k) - (((exp_tab(k) - exp_tab(k + 1)) * r + 2048) >>> 12);
    if (n == 0) return m;
    return (m + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Runs one accepted input sample through the filter; closes the block when due.
  function void note_sample(logic [15:0] smp, bit lst);
    longint x, acc, y, g, v;
    int cnt;
    x = longint'($signed(smp));
    acc = longint'(band_gain_c) * x + state_one;
    y = clip((acc + 32768) >>> 16, -32768, 32767);
    state_one = clip(-longint'(fb_one_c) * y + state_two, -64'sd2147483648, 64'sd2147483647);
    state_two = clip(-longint'(band_gain_c) * x - longint'(fb_two_c) * y,
                     -64'sd2147483648, 64'sd2147483647);
    orig_q.push_back(int'(x));
    band_q.push_back(int'(y));
    if ((y < 0 ? -y : y) > peak) peak = (y < 0 ? -y : y);
    if (!lst && orig_q.size() < 64) return;
    g = block_gain(level_db(peak));
    cnt = orig_q.size();
    for (int i = 0; i < cnt; i++) begin
      if (listen_c) v = band_q[i];
      else v = clip(orig_q[i] - band_q[i] + ((band_q[i] * g + 16384) >>> 15), -32768, 32767);
      exp_sample.push_back(v[15:0]);
      exp_last.push_back(i == cnt - 1 ? lst : 1'b0);
      exp_gain.push_back(g[15:0]);
    end
    orig_q = {}; band_q = {}; peak = 0;
    blocks_seen++;
  endfunction

  function void check_result(logic [31:0] data, logic lst);
    results_seen++;
    if (exp_sample.size() == 0) begin
      $display("%0t: unexpected result data=%h last=%b", $time, data, lst);
      errors++;
      return;
    end
    if (data[15:0] !== exp_sample[0] || data[31:16] !== exp_gain[0] || lst !== exp_last[0]) begin
      $display("%0t: mismatch expected sample=%h gain=%h last=%b, actual sample=%h gain=%h last=%b",
               $time, exp_sample[0], exp_gain[0], exp_last[0], data[15:0], data[31:16], lst);
      errors++;
    end
    void'(exp_sample.pop_front());
    void'(exp_gain.pop_front());
    void'(exp_last.pop_front());
  endfunction

  function int pending();
    return exp_sample.size();
  endfunction
endclass

module testbench;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [bpde_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bpde_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  deess_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int samples_sent = 0;

  block_peak_de_esser_top u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("FAIL block_peak_de_esser_top");
    $finish;
  end

  // The receiver stalls at random; results are checked at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  task automatic write_cfg(bpde_pkg::reg_idx_e idx, logic [18:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic send_sample(logic [15:0] smp, bit lst);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= smp;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp, lst);
    samples_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  // Waits until every result is in, then lets an open block's filter pipeline settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_all(logic [18:0] b0, logic [18:0] a1, logic [18:0] a2,
                         logic [18:0] thr, logic [18:0] slp, logic [18:0] rng, bit lsn);
    write_cfg(bpde_pkg::REG_BAND_GAIN, b0);
    write_cfg(bpde_pkg::REG_FEEDBACK_ONE, a1);
    write_cfg(bpde_pkg::REG_FEEDBACK_TWO, a2);
    write_cfg(bpde_pkg::REG_THRESHOLD_DB, thr);
    write_cfg(bpde_pkg::REG_SLOPE, slp);
    write_cfg(bpde_pkg::REG_RANGE_DB, rng);
    write_cfg(bpde_pkg::REG_LISTEN_MODE, 19'(lsn));
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(65535) >> $urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_blocks(int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? 64 + $urandom_range(10) : 1 + $urandom_range(11);
      for (int i = 0; i < len && left > 0; i++) begin
        send_sample(rand_sample(), i == len - 1);
        left--;
      end
    end
    // Close whatever is still open.
    send_sample(rand_sample(), 1'b1);
  endtask

  initial begin
    sb = new();
    sb.reset_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: reset settings, then a strong band with extreme samples.
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain();
    set_all(19'd65536, 19'h40000, 19'h10000, 19'h0, 19'd65535, 19'd25599, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h1234, 1'b1);
    drain();
    set_all(19'd40000, 19'h3ffff, 19'h2ffff, 19'h19C00, 19'd0, 19'd0, 1'b1);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hc000, 1'b1);
    // A full store without last closes on its own.
    for (int i = 0; i < 64; i++) send_sample(i[0] ? 16'h7fff : 16'h8000, 1'b0);
    send_sample(16'h0001, 1'b1);
    drain();

    // Random phases with different idling patterns and settings.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 31) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 31) : 0;
      set_all(19'($urandom_range(65536)), 19'($urandom_range(524287)),
              19'($urandom_range(262143)),
              ph == 0 ? 19'h0 : 19'h0 - 19'($urandom_range(25600)),
              19'($urandom_range(65535)), 19'($urandom_range(25599)), ph == 2);
      random_blocks(30);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_all(19'd20000, 19'h60000, 19'd30000, 19'h1EC00, 19'd49152, 19'd3072, 1'b0);
    random_blocks(30);
    drain();

    $display("Sent %0d samples in %0d blocks; checked %0d results over several settings.",
             samples_sent, sb.blocks_seen, sb.results_seen);
    if (sb.errors == 0) begin
      $display("PASS block_peak_de_esser_top");
    end else begin
      $display("FAIL block_peak_de_esser_top");
    end
    $finish;
  end
endmodule

`default_nettype wire

[block_peak_de_esser_top.f]
rtl/bpde_pkg.sv
rtl/bpde_ram.sv
rtl/bpde_fifo.sv
rtl/bpde_front.sv
rtl/bpde_back.sv
rtl/block_peak_de_esser_top.sv
verif/testbench.sv
